FILE: design/sr_pkg.sv
// ----------------------------------------------------------------------------
// sr_pkg
// Shared types, codes and helpers for the streaming string replace block.
// ----------------------------------------------------------------------------
package sr_pkg;

  localparam int unsigned CFG_IDX_W = 8;
  localparam int unsigned IDX_W     = 5;

  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LEN       = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_BYTES     = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_REPLACEMENT_LEN   = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_REPLACEMENT_BYTES = 8'd3;

  localparam logic [7:0] NEWLINE = 8'd10;

  // window control from the sequencer
  typedef struct packed {
    logic       shift;
    logic       append;
    logic       clear;
    logic [7:0] din;
  } win_ctl_t;

  // emitter control from the sequencer
  typedef struct packed {
    logic       push;
    logic       finish;
    logic [7:0] din;
  } em_ctl_t;

  // byte idx of a 64-bit register; bytes past the register read as zero
  function automatic logic [7:0] byte_of(input logic [63:0] word, input logic [IDX_W-1:0] idx);
    logic [7:0] res;
    res = 8'd0;
    if (idx < IDX_W'(8)) res = word[idx[2:0]*8 +: 8];
    return res;
  endfunction

endpackage

FILE: design/stream_string_replace_top.sv
// ----------------------------------------------------------------------------
// stream_string_replace_top
// Streaming find and replace over a byte stream with a held match window.
// ----------------------------------------------------------------------------
//  channel | dir | handshake             | payload
//  in_     | in  | in_tvalid/in_tready   | tdata[7:0] in_byte, tuser end_of_stream
//  out_    | out | out_tvalid/out_tready | tdata[7:0] out_byte, tlast last
//  cfg_    | in  | cfg_valid/cfg_ready   | cfg_index register, cfg_data value
//
// A text byte goes through accept, making room when the window is full, append,
// a compare of each window byte through the single comparator, the bytes dropped or
// replaced, and a closing state. A newline or end of stream goes through accept, a
// flush of the held bytes, the newline for a newline only, and the closing state.
// Reset is synchronous and clears the window count and the sequencer state.
// A stalled output holds the sequencer; configuration is always accepted.
// ----------------------------------------------------------------------------
module stream_string_replace_top #(
  parameter int unsigned MAX_PATTERN     = 8,
  parameter int unsigned MAX_REPLACEMENT = 8
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [7:0]                   in_tdata,   // [7:0] in_byte
  input  logic                         in_tuser,   // end_of_stream
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [7:0]                   out_tdata,  // [7:0] out_byte
  output logic                         out_tlast,  // last
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [sr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [63:0]                  cfg_data
);
  import sr_pkg::*;

  localparam int unsigned CW = $clog2(MAX_PATTERN + 1);
  localparam int unsigned IW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam int unsigned JW = (MAX_REPLACEMENT > 1) ? $clog2(MAX_REPLACEMENT) : 1;

  typedef enum logic [3:0] {
    S_IDLE, S_PRE, S_APPEND, S_CMP, S_DROP, S_REPL, S_FLUSH, S_NL, S_DONE
  } state_t;

  // configuration registers
  logic [3:0]  pattern_len_r;
  logic [63:0] pattern_bytes_r;
  logic [3:0]  replacement_len_r;
  logic [63:0] replacement_bytes_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pattern_len_r       <= 4'd1;
      pattern_bytes_r     <= '0;
      replacement_len_r   <= 4'd0;
      replacement_bytes_r <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_PATTERN_LEN:       pattern_len_r       <= cfg_data[3:0];
        REG_PATTERN_BYTES:     pattern_bytes_r     <= cfg_data;
        REG_REPLACEMENT_LEN:   replacement_len_r   <= cfg_data[3:0];
        REG_REPLACEMENT_BYTES: replacement_bytes_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // effective lengths: zero pattern counts as one, both saturate
  logic [5:0] plen_raw, plen_eff, rlen_eff;
  assign plen_raw = (pattern_len_r == 4'd0) ? 6'd1 : {2'b00, pattern_len_r};
  assign plen_eff = (plen_raw > 6'(MAX_PATTERN)) ? 6'(MAX_PATTERN) : plen_raw;
  assign rlen_eff = ({2'b00, replacement_len_r} > 6'(MAX_REPLACEMENT)) ?
                    6'(MAX_REPLACEMENT) : {2'b00, replacement_len_r};

  // sequencer
  state_t        state_r, state_nxt;
  logic [7:0]    b_r, b_nxt;
  logic          eos_r, eos_nxt;
  logic [IW-1:0] i_r, i_nxt;
  logic [JW-1:0] j_r, j_nxt;

  win_ctl_t      win_ctl;
  em_ctl_t       em_ctl;
  logic          em_ready;
  logic [7:0]    win_head;
  logic [CW-1:0] win_count;
  logic          win_match;
  logic [5:0]    count_w;

  assign count_w = 6'(win_count);

  always_comb begin
    state_nxt = state_r;
    b_nxt     = b_r;
    eos_nxt   = eos_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    win_ctl   = '0;
    em_ctl    = '0;
    in_tready = 1'b0;
    win_ctl.din = b_r;
    case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          b_nxt   = in_tdata;
          eos_nxt = in_tuser;
          if (in_tuser || in_tdata == NEWLINE) state_nxt = S_FLUSH;
          else state_nxt = S_PRE;
        end
      end
      S_PRE: begin
        // make room when the window is full
        if (win_count == CW'(MAX_PATTERN)) begin
          if (em_ready) begin
            em_ctl.push   = 1'b1;
            em_ctl.din    = win_head;
            win_ctl.shift = 1'b1;
            state_nxt     = S_APPEND;
          end
        end else begin
          state_nxt = S_APPEND;
        end
      end
      S_APPEND: begin
        win_ctl.append = 1'b1;
        i_nxt          = '0;
        state_nxt      = S_CMP;
      end
      S_CMP: begin
        if (win_count == '0) begin
          state_nxt = S_DONE;
        end else if (count_w > plen_eff || !win_match) begin
          state_nxt = S_DROP;
        end else if ((CW'(i_r) + CW'(1)) == win_count) begin
          // window is a prefix; a full match is replaced
          if (count_w == plen_eff) begin
            win_ctl.clear = 1'b1;
            j_nxt         = '0;
            state_nxt     = (rlen_eff != 6'd0) ? S_REPL : S_DONE;
          end else begin
            state_nxt = S_DONE;
          end
        end else begin
          i_nxt = i_r + IW'(1);
        end
      end
      S_DROP: begin
        if (em_ready) begin
          em_ctl.push   = 1'b1;
          em_ctl.din    = win_head;
          win_ctl.shift = 1'b1;
          i_nxt         = '0;
          state_nxt     = S_CMP;
        end
      end
      S_REPL: begin
        if (em_ready) begin
          em_ctl.push = 1'b1;
          em_ctl.din  = byte_of(replacement_bytes_r, IDX_W'(j_r));
          if ((6'(j_r) + 6'd1) == rlen_eff) state_nxt = S_DONE;
          else j_nxt = j_r + JW'(1);
        end
      end
      S_FLUSH: begin
        if (win_count == '0) begin
          state_nxt = eos_r ? S_DONE : S_NL;
        end else if (em_ready) begin
          em_ctl.push   = 1'b1;
          em_ctl.din    = win_head;
          win_ctl.shift = 1'b1;
        end
      end
      S_NL: begin
        if (em_ready) begin
          em_ctl.push = 1'b1;
          em_ctl.din  = NEWLINE;
          state_nxt   = S_DONE;
        end
      end
      S_DONE: begin
        // mark the last byte of this transaction
        if (em_ready) begin
          em_ctl.finish = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    b_r   <= b_nxt;
    eos_r <= eos_nxt;
    i_r   <= i_nxt;
    j_r   <= j_nxt;
  end

  sr_window #(
    .MAX_PATTERN(MAX_PATTERN),
    .CW         (CW),
    .IW         (IW)
  ) u_window (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (win_ctl),
    .rd_idx  (i_r),
    .cmp_byte(byte_of(pattern_bytes_r, IDX_W'(i_r))),
    .head    (win_head),
    .count   (win_count),
    .match   (win_match)
  );

  sr_emit u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (em_ctl),
    .ready     (em_ready),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    win_count <= CW'(MAX_PATTERN))
    else $error("window count beyond depth");

  a_push_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (em_ctl.push || em_ctl.finish) |-> em_ready)
    else $error("emit while output stage full");

  a_flush_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && eos_r) |-> (win_count == '0))
    else $error("window not empty after end of stream");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input accepted while item still in progress");

endmodule

FILE: design/sr_window.sv
// ----------------------------------------------------------------------------
// sr_window
// Held byte window with fill count and the shared byte comparator.
// ----------------------------------------------------------------------------
module sr_window #(
  parameter int unsigned MAX_PATTERN = 8,
  parameter int unsigned CW = $clog2(MAX_PATTERN + 1),
  parameter int unsigned IW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1
) (
  input  logic             clk,
  input  logic             rst_n,
  input  sr_pkg::win_ctl_t ctl,
  input  logic [IW-1:0]    rd_idx,
  input  logic [7:0]       cmp_byte,
  output logic [7:0]       head,
  output logic [CW-1:0]    count,
  output logic             match
);
  import sr_pkg::*;

  logic [7:0]    win_r [MAX_PATTERN];
  logic [CW-1:0] count_r;
  logic [CW-1:0] count_nxt;

  always_comb begin
    count_nxt = count_r;
    if (ctl.clear) begin
      count_nxt = '0;
    end else if (ctl.shift) begin
      count_nxt = count_r - CW'(1);
    end else if (ctl.append) begin
      count_nxt = count_r + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  // storage needs no reset: only the first count entries are read
  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      for (int k = 0; k < int'(MAX_PATTERN) - 1; k++) begin
        win_r[k] <= win_r[k+1];
      end
    end else if (ctl.append) begin
      win_r[count_r[IW-1:0]] <= ctl.din;
    end
  end

  assign head  = win_r[0];
  assign count = count_r;
  assign match = (win_r[rd_idx] == cmp_byte);

endmodule

FILE: design/sr_emit.sv
// ----------------------------------------------------------------------------
// sr_emit
// Output stage: one pending byte plus the output register, so the final
// byte of a transaction group can be marked with tlast.
// ----------------------------------------------------------------------------
module sr_emit (
  input  logic            clk,
  input  logic            rst_n,
  input  sr_pkg::em_ctl_t ctl,
  output logic            ready,
  output logic            out_tvalid,
  input  logic            out_tready,
  output logic [7:0]      out_tdata,   // [7:0] out_byte
  output logic            out_tlast    // last
);
  import sr_pkg::*;

  logic       pend_v_r, pend_v_nxt;
  logic [7:0] pend_byte_r, pend_byte_nxt;
  logic       out_v_r, out_v_nxt;
  logic [7:0] out_byte_r, out_byte_nxt;
  logic       out_last_r, out_last_nxt;
  logic       out_free;

  assign out_free = !out_v_r || out_tready;
  assign ready    = !pend_v_r || out_free;

  always_comb begin
    pend_v_nxt    = pend_v_r;
    pend_byte_nxt = pend_byte_r;
    out_v_nxt     = out_v_r && !out_tready;
    out_byte_nxt  = out_byte_r;
    out_last_nxt  = out_last_r;
    if (ctl.push && ready) begin
      // advance the pending byte; it is not the last one
      if (pend_v_r) begin
        out_v_nxt    = 1'b1;
        out_byte_nxt = pend_byte_r;
        out_last_nxt = 1'b0;
      end
      pend_v_nxt    = 1'b1;
      pend_byte_nxt = ctl.din;
    end else if (ctl.finish && ready && pend_v_r) begin
      out_v_nxt    = 1'b1;
      out_byte_nxt = pend_byte_r;
      out_last_nxt = 1'b1;
      pend_v_nxt   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_v_r <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      pend_v_r <= pend_v_nxt;
      out_v_r  <= out_v_nxt;
    end
    pend_byte_r <= pend_byte_nxt;
    out_byte_r  <= out_byte_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_byte_r;
  assign out_tlast  = out_last_r;

endmodule

FILE: bench/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the streaming find and replace block. Each accepted
// text byte is run through a local rewrite predictor that keeps its own match
// window and register copies. The rewritten bytes it forecasts are queued and
// compared with every transaction on the output stream. A directed table goes
// first, then random phases that change the pattern and replacement between
// bursts of text.
// ----------------------------------------------------------------------------
module tb;
  import sr_pkg::*;

  localparam int unsigned MAX_PAT     = 8;
  localparam int unsigned MAX_REP     = 8;
  localparam int unsigned N_PHASES    = 8;
  localparam int unsigned PHASE_ITEMS = 53;
  localparam int unsigned DRAIN       = 32;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned HOLD_AFTER  = 150;
  localparam int unsigned STALL_LIMIT = 4000;
  localparam int unsigned N_ROWS      = 36;

  typedef enum logic { ROW_ITEM, ROW_CFG } row_kind_t;
  typedef enum logic [1:0] { EXP_PREDICT, EXP_NONE, EXP_ONE } check_t;

  typedef struct packed {
    row_kind_t            kind;
    logic [CFG_IDX_W-1:0] idx;
    logic [63:0]          data;   // register value, or text byte in [7:0]
    logic                 eos;
    check_t               check;
    logic [7:0]           want;
  } row_t;

  typedef struct packed {
    logic [7:0] b;
    logic       eos;
  } text_item_t;

  typedef struct packed {
    logic [7:0] b;
    logic       last;
  } out_beat_t;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 in_tvalid;
  logic                 in_tready;
  logic [7:0]           in_tdata;   // [7:0] in_byte
  logic                 in_tuser;   // end_of_stream
  logic                 out_tvalid;
  logic                 out_tready;
  logic [7:0]           out_tdata;  // [7:0] out_byte
  logic                 out_tlast;  // last
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [63:0]          cfg_data;

  // predictor state: register copies and match window
  logic [3:0]  pat_len_sh = 4'd1;
  logic [63:0] pat_sh     = '0;
  logic [3:0]  rep_len_sh = 4'd0;
  logic [63:0] rep_sh     = '0;
  logic [7:0]  win [MAX_PAT];
  int unsigned win_cnt    = 0;

  logic [7:0]  emitted [$];
  out_beat_t   rewritten_q [$];
  out_beat_t   want_beat;
  row_t        directed_rows [0:N_ROWS-1];

  int unsigned mismatches   = 0;
  int unsigned results_seen = 0;
  int unsigned stall_cycles = 0;
  bit          held_off     = 1'b0;

  stream_string_replace_top #(
    .MAX_PATTERN     (MAX_PAT),
    .MAX_REPLACEMENT (MAX_REP)
  ) i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic int unsigned pattern_span();
    int unsigned n;
    n = pat_len_sh;
    if (n == 0) n = 1;
    if (n > MAX_PAT) n = MAX_PAT;
    return n;
  endfunction

  function automatic void flush_window();
    int unsigned i;
    for (i = 0; i < win_cnt; i++) emitted.push_back(win[i]);
    win_cnt = 0;
  endfunction

  function automatic void drop_oldest();
    int unsigned i;
    emitted.push_back(win[0]);
    for (i = 1; i < win_cnt; i++) win[i-1] = win[i];
    win_cnt--;
  endfunction

  // Rewrite one text byte; the bytes it releases land in emitted.
  function automatic void rewrite_step(input logic [7:0] b, input logic eos);
    int unsigned plen;
    int unsigned rlen;
    int unsigned i;
    bit          prefix;
    bit          done;
    emitted.delete();
    if (eos) begin
      flush_window();
    end else if (b == NEWLINE) begin
      flush_window();
      emitted.push_back(b);
    end else begin
      if (win_cnt >= MAX_PAT) drop_oldest();
      win[win_cnt] = b;
      win_cnt++;
      plen = pattern_span();
      rlen = (rep_len_sh > MAX_REP) ? MAX_REP : rep_len_sh;
      done = 1'b0;
      // rescan: shed the oldest byte until the window is a prefix again
      while (win_cnt != 0 && !done) begin
        prefix = (win_cnt <= plen);
        for (i = 0; i < win_cnt; i++)
          if (win[i] != pat_sh[8*i +: 8]) prefix = 1'b0;
        if (prefix) begin
          if (win_cnt == plen) begin
            for (i = 0; i < rlen; i++) emitted.push_back(rep_sh[8*i +: 8]);
            win_cnt = 0;
          end
          done = 1'b1;
        end else begin
          drop_oldest();
        end
      end
    end
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] val);
    cfg_index <= idx;
    cfg_data  <= val;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_PATTERN_LEN:       pat_len_sh = val[3:0];
      REG_PATTERN_BYTES:     pat_sh     = val;
      REG_REPLACEMENT_LEN:   rep_len_sh = val[3:0];
      REG_REPLACEMENT_BYTES: rep_sh     = val;
      default: ;
    endcase
  endtask

  // Hold until every forecast byte is out, then let a byte with no output finish.
  task automatic wait_idle();
    while (rewritten_q.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  task automatic send_byte(input logic [7:0] b, input logic eos, input logic more,
                           input check_t check, input logic [7:0] want);
    int unsigned gap;
    int unsigned r;
    int unsigned k;
    in_tdata  <= b;
    in_tuser  <= eos;
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    rewrite_step(b, eos);
    case (check)
      EXP_PREDICT:
        for (k = 0; k < emitted.size(); k++)
          rewritten_q.push_back('{b: emitted[k], last: (k + 1 == emitted.size())});
      EXP_ONE: rewritten_q.push_back('{b: want, last: 1'b1});
      default: ;
    endcase
    r = $urandom_range(0, 99);
    if (r < 55)      gap = 0;
    else if (r < 88) gap = $urandom_range(1, 3);
    else             gap = $urandom_range(8, 30);
    if (!more || gap != 0) in_tvalid <= 1'b0;
    repeat (gap) @(posedge clk);
  endtask

  // output checker and stall watchdog
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      results_seen++;
      if (rewritten_q.size() == 0) begin
        $error("out_byte: no transaction expected, got %02h", out_tdata);
        mismatches++;
      end else begin
        want_beat = rewritten_q.pop_front();
        if (out_tdata !== want_beat.b) begin
          $error("out_byte: expected %02h, got %02h", want_beat.b, out_tdata);
          mismatches++;
        end
        if (out_tlast !== want_beat.last) begin
          $error("last: expected %0b, got %0b", want_beat.last, out_tlast);
          mismatches++;
        end
      end
    end
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      stall_cycles = 0;
    else
      stall_cycles++;
    if (stall_cycles == STALL_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // output back-pressure, with one long hold-off to fill the block
  initial begin
    int unsigned r;
    int unsigned len;
    logic        val;
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!held_off && results_seen >= HOLD_AFTER) begin
        held_off = 1'b1;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(posedge clk);
      end else begin
        r = $urandom_range(0, 99);
        if (r < 50) begin
          val = 1'b1; len = $urandom_range(1, 12);
        end else if (r < 85) begin
          val = 1'b0; len = $urandom_range(1, 3);
        end else if (r < 95) begin
          val = 1'b1; len = $urandom_range(30, 60);
        end else begin
          val = 1'b0; len = $urandom_range(15, 40);
        end
        out_tready <= val;
        repeat (len - 1) @(posedge clk);
      end
    end
  end

  initial begin
    text_item_t  text [$];
    int unsigned i;
    int unsigned k;
    int unsigned n;
    int unsigned r;
    int unsigned span;
    int unsigned phase;
    logic        next_same;
    logic [3:0]  plen_v;
    logic [3:0]  rlen_v;
    logic [63:0] pat_v;
    logic [63:0] rep_v;

    // kind, index, value, eos, check, expected byte
    directed_rows = '{
      '{ROW_ITEM, 8'd0, 64'h41, 1'b0, EXP_ONE, 8'h41},      // no match on reset pattern
      '{ROW_ITEM, 8'd0, 64'h00, 1'b0, EXP_NONE, 8'h00},     // zero byte deleted
      '{ROW_ITEM, 8'd0, 64'hFF, 1'b0, EXP_ONE, 8'hFF},
      '{ROW_ITEM, 8'd0, 64'h0A, 1'b0, EXP_ONE, 8'h0A},
      '{ROW_ITEM, 8'd0, 64'hFF, 1'b1, EXP_NONE, 8'h00},     // flush of an empty window
      '{ROW_CFG, REG_PATTERN_LEN, 64'd3, 1'b0, EXP_NONE, 8'h00},
      '{ROW_CFG, REG_PATTERN_BYTES, 64'h636261, 1'b0, EXP_NONE, 8'h00},   // "abc"
      '{ROW_CFG, REG_REPLACEMENT_LEN, 64'd8, 1'b0, EXP_NONE, 8'h00},
      '{ROW_CFG, REG_REPLACEMENT_BYTES, '1, 1'b0, EXP_NONE, 8'h00},
      '{ROW_ITEM, 8'd0, 64'h61, 1'b0, EXP_NONE, 8'h00},
      '{ROW_ITEM, 8'd0, 64'h61, 1'b0, EXP_ONE, 8'h61},      // "aa": oldest released
      '{ROW_ITEM, 8'd0, 64'h62, 1'b0, EXP_NONE, 8'h00},
      '{ROW_ITEM, 8'd0, 64'h63, 1'b0, EXP_PREDICT, 8'h00},
      '{ROW_ITEM, 8'd0, 64'h61, 1'b0, EXP_NONE, 8'h00},
      '{ROW_ITEM, 8'd0, 64'h62, 1'b0, EXP_NONE, 8'h00},
      '{ROW_ITEM, 8'd0, 64'h0A, 1'b0, EXP_PREDICT, 8'h00},  // newline breaks a match
      '{ROW_ITEM, 8'd0, 64'h61, 1'b0, EXP_NONE, 8'h00},
      '{ROW_ITEM, 8'd0, 64'h62, 1'b0, EXP_NONE, 8'h00},
      '{ROW_ITEM, 8'd0, 64'h00, 1'b1, EXP_PREDICT, 8'h00},
      '{ROW_ITEM, 8'd0, 64'h61, 1'b0, EXP_NONE, 8'h00},
      '{ROW_ITEM, 8'd0, 64'h62, 1'b0, EXP_NONE, 8'h00},
      // shrink the pattern while two bytes are held; zero length reads as one
      '{ROW_CFG, REG_PATTERN_LEN, 64'd0, 1'b0, EXP_NONE, 8'h00},
      '{ROW_CFG, REG_REPLACEMENT_LEN, 64'd0, 1'b0, EXP_NONE, 8'h00},
      '{ROW_ITEM, 8'd0, 64'h78, 1'b0, EXP_PREDICT, 8'h00},
      // pattern holding a newline never matches
      '{ROW_CFG, REG_PATTERN_LEN, 64'd2, 1'b0, EXP_NONE, 8'h00},
      '{ROW_CFG, REG_PATTERN_BYTES, 64'h610A, 1'b0, EXP_NONE, 8'h00},
      '{ROW_CFG, 8'd4, '1, 1'b0, EXP_NONE, 8'h00},
      '{ROW_CFG, 8'hFF, '1, 1'b0, EXP_NONE, 8'h00},
      '{ROW_ITEM, 8'd0, 64'h0A, 1'b0, EXP_ONE, 8'h0A},
      '{ROW_ITEM, 8'd0, 64'h61, 1'b0, EXP_ONE, 8'h61},
      // oversized replacement length saturates
      '{ROW_CFG, REG_PATTERN_LEN, 64'd1, 1'b0, EXP_NONE, 8'h00},
      '{ROW_CFG, REG_PATTERN_BYTES, 64'h7A, 1'b0, EXP_NONE, 8'h00},
      '{ROW_CFG, REG_REPLACEMENT_LEN, 64'hF, 1'b0, EXP_NONE, 8'h00},
      '{ROW_CFG, REG_REPLACEMENT_BYTES, 64'h0123456789ABCDEF, 1'b0, EXP_NONE, 8'h00},
      '{ROW_ITEM, 8'd0, 64'h7A, 1'b0, EXP_PREDICT, 8'h00},
      '{ROW_ITEM, 8'd0, 64'h00, 1'b1, EXP_NONE, 8'h00}
    };

    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    for (i = 0; i < N_ROWS; i++) begin
      next_same = (i + 1 < N_ROWS) && (directed_rows[i+1].kind == directed_rows[i].kind);
      if (directed_rows[i].kind == ROW_CFG) begin
        if (i == 0 || directed_rows[i-1].kind != ROW_CFG) wait_idle();
        write_reg(directed_rows[i].idx, directed_rows[i].data);
        if (!next_same) cfg_valid <= 1'b0;
      end else begin
        send_byte(directed_rows[i].data[7:0], directed_rows[i].eos, next_same,
                  directed_rows[i].check, directed_rows[i].want);
      end
    end

    for (phase = 0; phase < N_PHASES; phase++) begin
      wait_idle();
      // pattern drawn mostly from a small alphabet so that matches are common
      for (k = 0; k < 8; k++) begin
        r = $urandom_range(0, 99);
        if (r < 70)      pat_v[8*k +: 8] = 8'h61 + 8'($urandom_range(0, 2));
        else if (r < 95) pat_v[8*k +: 8] = 8'($urandom_range(0, 255));
        else             pat_v[8*k +: 8] = NEWLINE;
      end
      rep_v = {$urandom, $urandom};
      r = $urandom_range(0, 9);
      if (r == 0)      plen_v = 4'd0;
      else if (r == 1) plen_v = 4'd8;
      else if (r == 2) plen_v = 4'($urandom_range(9, 15));
      else             plen_v = 4'($urandom_range(1, 4));
      r = $urandom_range(0, 9);
      if (r == 0)      rlen_v = 4'd0;
      else if (r == 1) rlen_v = 4'd8;
      else if (r == 2) rlen_v = 4'($urandom_range(9, 15));
      else             rlen_v = 4'($urandom_range(0, 5));
      // pin the register extremes in the first phases
      if (phase == 0) begin
        plen_v = 4'd8; pat_v = '0; rlen_v = 4'hF;
      end else if (phase == 1) begin
        plen_v = 4'hF; pat_v = '1; rlen_v = 4'd8; rep_v = '1;
      end else if (phase == 2) begin
        plen_v = 4'd1; rlen_v = 4'd0; rep_v = '0;
      end
      write_reg(REG_PATTERN_LEN, 64'(plen_v));
      write_reg(REG_PATTERN_BYTES, pat_v);
      write_reg(REG_REPLACEMENT_LEN, 64'(rlen_v));
      write_reg(REG_REPLACEMENT_BYTES, rep_v);
      if ($urandom_range(0, 1) != 0)
        write_reg(CFG_IDX_W'($urandom_range(4, 255)), {$urandom, $urandom});
      cfg_valid <= 1'b0;

      text.delete();
      span = pattern_span();
      while (text.size() < PHASE_ITEMS) begin
        r = $urandom_range(0, 99);
        if (r < 45) begin
          if ($urandom_range(0, 3) == 0)
            text.push_back('{b: pat_sh[8*$urandom_range(0, span - 1) +: 8], eos: 1'b0});
          for (k = 0; k < span; k++) text.push_back('{b: pat_sh[8*k +: 8], eos: 1'b0});
        end else if (r < 60) begin
          // broken occurrence: a prefix cut short by a stray byte
          n = $urandom_range(1, span);
          for (k = 0; k + 1 < n; k++) text.push_back('{b: pat_sh[8*k +: 8], eos: 1'b0});
          text.push_back('{b: 8'($urandom_range(0, 255)), eos: 1'b0});
        end else if (r < 82) begin
          text.push_back('{b: pat_sh[8*$urandom_range(0, span - 1) +: 8], eos: 1'b0});
        end else if (r < 92) begin
          text.push_back('{b: 8'($urandom_range(0, 255)), eos: 1'b0});
        end else if (r < 96) begin
          text.push_back('{b: NEWLINE, eos: 1'b0});
        end else begin
          text.push_back('{b: 8'($urandom_range(0, 255)), eos: 1'b1});
        end
      end
      for (k = 0; k < text.size(); k++)
        send_byte(text[k].b, text[k].eos, k + 1 < text.size(), EXP_PREDICT, 8'h00);
    end

    wait_idle();
    if (mismatches == 0 && rewritten_q.size() == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
